// ----- rtl/core/daaq_pkg.sv -----
// shared constants and controller/datapath command type for the admission queue
// no dependencies
`timescale 1ns / 1ps

package daaq_pkg;

  // table geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int ID_W = 16;
  localparam int DIR_W = 3;
  localparam int GRANT_W = 5;
  localparam int CMP_W = (CNT_W > GRANT_W) ? CNT_W : GRANT_W;

  // grant limit after reset
  localparam logic [GRANT_W-1:0] RESET_GRANT_LIMIT = GRANT_W'(4);

  // mode codes
  localparam logic MODE_REQUEST = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;    // capture the accepted item
    logic lookup;  // register the id search
    logic apply;   // update the table and register the result
  } daaq_cmd_t;

endpackage

// ----- rtl/core/daaq_datapath.sv -----
// waiting table, id search, conflict check, append and compaction
// depends on daaq_pkg
`timescale 1ns / 1ps

module daaq_datapath
  import daaq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  daaq_cmd_t          cmd,
  input  logic               max_grants_we,
  input  logic [GRANT_W-1:0] max_grants,
  input  logic               mode,
  input  logic [ID_W-1:0]    requester_id,
  input  logic [DIR_W-1:0]   direction,
  output logic               answer,
  output logic               overflow
);

  logic [ID_W-1:0]    entry_ids [QUEUE_DEPTH];
  logic [DIR_W-1:0]   entry_dirs [QUEUE_DEPTH];
  logic [CNT_W-1:0]   entry_count;
  logic [GRANT_W-1:0] grant_limit;

  logic               item_mode;
  logic [ID_W-1:0]    item_id;
  logic [DIR_W-1:0]   item_dir;

  logic               found;
  logic [CNT_W-1:0]   pos;

  logic               match_found;
  logic [CNT_W-1:0]   match_pos;
  logic               full;
  logic [CNT_W-1:0]   grant_pos;
  logic               conflict;
  logic               grant;

  // grant limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      grant_limit <= RESET_GRANT_LIMIT;
    end else if (max_grants_we) begin
      grant_limit <= max_grants;
    end
  end

  // item capture on transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode <= mode;
      item_id   <= requester_id;
      item_dir  <= direction;
    end
  end

  // first matching valid entry
  always_comb begin
    match_found = 1'b0;
    match_pos   = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < entry_count && entry_ids[i] == item_id) begin
        match_found = 1'b1;
        match_pos   = CNT_W'(i);
      end
    end
  end

  // search result register
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      found <= match_found;
      pos   <= match_pos;
    end
  end

  // position used for the grant: listed entry or the append slot
  assign full      = (entry_count == CNT_W'(QUEUE_DEPTH));
  assign grant_pos = found ? pos : entry_count;

  // any entry ahead with another direction
  always_comb begin
    conflict = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (CNT_W'(i) < grant_pos && entry_dirs[i] != item_dir) begin
        conflict = 1'b1;
      end
    end
  end

  assign grant = (CMP_W'(grant_pos) < CMP_W'(grant_limit)) && !conflict;

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.apply) begin
      if (item_mode == MODE_REQUEST) begin
        if (!found && !full) begin
          entry_count <= entry_count + CNT_W'(1);
        end
      end else if (found) begin
        entry_count <= entry_count - CNT_W'(1);
      end
    end
  end

  // table update: append at the tail or close the gap on release
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (item_mode == MODE_REQUEST) begin
        if (!found && !full) begin
          entry_ids[entry_count[IDX_W-1:0]]  <= item_id;
          entry_dirs[entry_count[IDX_W-1:0]] <= item_dir;
        end
      end else if (found) begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (CNT_W'(i) >= pos) begin
            entry_ids[i]  <= entry_ids[i+1];
            entry_dirs[i] <= entry_dirs[i+1];
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      if (item_mode == MODE_REQUEST) begin
        answer   <= (found || !full) && grant;
        overflow <= !found && full;
      end else begin
        answer   <= found;
        overflow <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/core/daaq_ctrl.sv -----
// sequencing of one item: capture, lookup, apply
// depends on daaq_pkg
`timescale 1ns / 1ps

module daaq_ctrl
  import daaq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  output daaq_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_LOOKUP = 2'd1;
  localparam logic [1:0] S_APPLY  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       take;

  // a new item may enter while the previous one is applied
  assign busy = (state == S_LOOKUP);
  assign take = start && !busy;

  assign cmd.load   = take;
  assign cmd.lookup = (state == S_LOOKUP);
  assign cmd.apply  = (state == S_APPLY);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   state_next = take ? S_LOOKUP : S_IDLE;
      S_LOOKUP: state_next = S_APPLY;
      S_APPLY:  state_next = take ? S_LOOKUP : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_APPLY);
    end
  end

endmodule

// ----- rtl/core/direction_aware_admission_queue_unit.sv -----
// Direction-aware admission queue: an ordered table of (id, direction) pairs.
//
// Use: raise start with mode, requester_id and direction; the transfer takes
// place at an edge where busy is low. mode 0 requests access (the id is
// appended if unlisted), mode 1 releases it (entry removed, gap closed).
// The result is registered on answer and overflow in the apply step, marked
// by done, a one-cycle strobe; answer and overflow hold until the next item
// is applied. A new item can be accepted while the previous one is applied,
// not during its search: the parallel id search over the table registers
// comes first, then the conflict check and the append or shift. busy is
// high only during the search cycle. The user is to write max_grants through
// max_grants_we only while no item is in flight (the block does not enforce
// this); the grant limit resets to 4. Reset (rst, synchronous) empties the
// table; stored ids and directions are not cleared, only the entry count.
// The receiver cannot stall: done is a one-cycle strobe with no back-pressure.
// depends on daaq_pkg, daaq_ctrl, daaq_datapath
`timescale 1ns / 1ps

module direction_aware_admission_queue_unit
  import daaq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               mode,
  input  logic [ID_W-1:0]    requester_id,
  input  logic [DIR_W-1:0]   direction,
  input  logic               max_grants_we,
  input  logic [GRANT_W-1:0] max_grants,
  output logic               done,
  output logic               answer,
  output logic               overflow
);

  daaq_cmd_t cmd;

  // controller
  daaq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // datapath
  daaq_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .max_grants_we (max_grants_we),
    .max_grants    (max_grants),
    .mode          (mode),
    .requester_id  (requester_id),
    .direction     (direction),
    .answer        (answer),
    .overflow      (overflow)
  );

endmodule
